FILE: src/assert_macros.svh
// Assertion macros shared by the I2C master RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define ASSERT_IMPLIES(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(name, clk, rst, ante, cons)
`define ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: src/i2cm_pkg.sv
// Types and constants for the I2C master register access block.
package i2cm_pkg;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      CMD_TICK   = 2'd0,
      CMD_WRITE  = 2'd1,
      CMD_READ   = 2'd2,
      CMD_SUPPLY = 2'd3
   } cmd_kind_type;

   typedef enum logic [3:0] {
      PH_IDLE   = 4'd0,
      PH_START1 = 4'd1,
      PH_ADDRW  = 4'd2,
      PH_REG    = 4'd3,
      PH_DATA   = 4'd4,
      PH_START2 = 4'd5,
      PH_ADDRR  = 4'd6,
      PH_RECV   = 4'd7,
      PH_MACK   = 4'd8,
      PH_STOP   = 4'd9
   } phase_type;

   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_ADDR_NACK = 3'd1;
   localparam logic [2:0] ERR_REG_NACK  = 3'd2;
   localparam logic [2:0] ERR_DATA_NACK = 3'd3;
   localparam logic [2:0] ERR_RADR_NACK = 3'd4;

   typedef struct packed {
      cmd_kind_type kind;
      logic [6:0]   dev_addr;
      logic [7:0]   reg_addr;
      logic [15:0]  byte_count;
      logic [7:0]   write_byte;
      logic         sda_sample;
   } cmd_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic [7:0] read_byte;
      logic       read_valid;
      logic       read_last;
      logic       need_byte;
      logic       busy;
      logic       done;
      logic [2:0] error_code;
   } result_type;

endpackage

FILE: src/i2cm_front.sv
// Front end: accepts request transfers, decodes them and queues two deep.
`include "assert_macros.svh"

module i2cm_front
   import i2cm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dev_addr[6:0], reg_addr[14:7], byte_count[30:15], write_byte[38:31], sda_in[39]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  cmd_valid,
   output cmd_type               cmd,
   input  logic                  cmd_pop
);

   logic [1:0]   count_ff, count_in;
   cmd_type      head_ff, head_in;
   cmd_type      tail_ff, tail_in;
   cmd_type      new_cmd;
   cmd_kind_type kind;
   logic         push;

   assign kind = cmd_kind_type'(req_tuser);

   always_comb begin
      new_cmd.kind       = kind;
      new_cmd.dev_addr   = req_tdata[6:0];
      new_cmd.reg_addr   = req_tdata[14:7];
      new_cmd.byte_count = req_tdata[30:15];
      new_cmd.write_byte = req_tdata[38:31];
      new_cmd.sda_sample = req_tdata[39];
   end

   assign req_tready = (count_ff != 2'd2);
   assign push       = req_tvalid && req_tready;
   assign cmd_valid  = (count_ff != 2'd0);
   assign cmd        = head_ff;

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = new_cmd;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && cmd_pop) begin
               head_in = new_cmd;
            end else if (push) begin
               tail_in  = new_cmd;
               count_in = 2'd2;
            end else if (cmd_pop) begin
               count_in = 2'd0;
            end
         end
         default: begin
            if (cmd_pop) begin
               head_in  = tail_ff;
               count_in = 2'd1;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   `ASSERT_IMPLIES(a_count_range, clock, reset, 1'b1, count_ff <= 2'd2)
   `ASSERT_IMPLIES(a_pop_nonempty, clock, reset, cmd_pop, count_ff != 2'd0)
   `ASSERT_NEXT(a_pop_only, clock, reset, cmd_pop && !push, count_ff == $past(count_ff) - 2'd1)

endmodule

FILE: src/i2cm_engine.sv
// Back end: bus sequencer, one quarter-bit tick per command, with result register.
`include "assert_macros.svh"

module i2cm_engine
   import i2cm_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       cmd_valid,
   input  cmd_type    cmd,
   output logic       cmd_pop,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output result_type rsp
);

   localparam int CW_EXT = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;

   phase_type              phase_ff, phase_in;
   logic [1:0]             step_ff, step_in;
   logic [3:0]             bit_idx_ff, bit_idx_in;
   logic [7:0]             shift_ff, shift_in;
   logic [COUNT_WIDTH-1:0] left_ff, left_in;
   logic [7:0]             held_ff, held_in;
   logic                   held_valid_ff, held_valid_in;
   logic                   is_read_ff, is_read_in;
   logic [6:0]             slave_ff, slave_in;
   logic [7:0]             reg_ff, reg_in;
   logic [2:0]             err_ff, err_in;
   logic                   scl_ff, scl_in;
   logic                   sda_ff, sda_in;
   logic                   rsp_valid_ff;
   result_type             rsp_ff, res_in;
   logic [CW_EXT-1:0]      count_ext;
   logic                   chain;
   logic                   advance;

   assign advance   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign cmd_pop   = advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign count_ext = CW_EXT'(cmd.byte_count);

   always_comb begin
      phase_in      = phase_ff;
      step_in       = step_ff;
      bit_idx_in    = bit_idx_ff;
      shift_in      = shift_ff;
      left_in       = left_ff;
      held_in       = held_ff;
      held_valid_in = held_valid_ff;
      is_read_in    = is_read_ff;
      slave_in      = slave_ff;
      reg_in        = reg_ff;
      err_in        = err_ff;
      scl_in        = scl_ff;
      sda_in        = sda_ff;
      chain         = 1'b0;
      res_in        = '0;

      if (cmd.kind == CMD_SUPPLY) begin
         held_in       = cmd.write_byte;
         held_valid_in = 1'b1;
      end else if ((cmd.kind == CMD_WRITE || cmd.kind == CMD_READ) && phase_ff == PH_IDLE) begin
         slave_in      = cmd.dev_addr;
         reg_in        = cmd.reg_addr;
         left_in       = count_ext[COUNT_WIDTH-1:0];
         is_read_in    = (cmd.kind == CMD_READ);
         held_valid_in = 1'b0;
         err_in        = ERR_OK;
         phase_in      = PH_START1;
         step_in       = 2'd0;
         bit_idx_in    = 4'd0;
      end

      unique case (phase_in)
         PH_IDLE: begin
         end
         PH_START1, PH_START2: begin
            case (step_in)
               2'd0: begin sda_in = 1'b1; step_in = 2'd1; end
               2'd1: begin scl_in = 1'b1; step_in = 2'd2; end
               2'd2: begin sda_in = 1'b0; step_in = 2'd3; end
               default: begin
                  scl_in     = 1'b0;
                  shift_in   = {slave_in, phase_in == PH_START2};
                  phase_in   = (phase_in == PH_START1) ? PH_ADDRW : PH_ADDRR;
                  step_in    = 2'd0;
                  bit_idx_in = 4'd0;
               end
            endcase
         end
         PH_ADDRW, PH_REG, PH_DATA, PH_ADDRR: begin
            if (!bit_idx_in[3]) begin
               case (step_in)
                  2'd0: begin
                     if (phase_in == PH_DATA && bit_idx_in == 4'd0 && !held_valid_in) begin
                        res_in.need_byte = 1'b1;
                     end else begin
                        if (phase_in == PH_DATA && bit_idx_in == 4'd0) begin
                           shift_in      = held_in;
                           held_valid_in = 1'b0;
                        end
                        sda_in  = shift_in[7];
                        step_in = 2'd1;
                     end
                  end
                  2'd1: begin scl_in = 1'b1; step_in = 2'd2; end
                  default: begin
                     scl_in     = 1'b0;
                     shift_in   = {shift_in[6:0], 1'b0};
                     bit_idx_in = bit_idx_in + 4'd1;
                     step_in    = 2'd0;
                  end
               endcase
            end else begin
               case (step_in)
                  2'd0: begin sda_in = 1'b1; step_in = 2'd1; end
                  2'd1: begin
                     scl_in   = 1'b1;
                     shift_in = {7'd0, cmd.sda_sample};
                     step_in  = 2'd2;
                  end
                  default: begin
                     scl_in = 1'b0;
                     if (shift_in[0]) begin
                        sda_in = 1'b0;
                        unique case (phase_in)
                           PH_ADDRW: err_in = ERR_ADDR_NACK;
                           PH_REG:   err_in = ERR_REG_NACK;
                           PH_DATA:  err_in = ERR_DATA_NACK;
                           default:  err_in = ERR_RADR_NACK;
                        endcase
                        phase_in   = PH_STOP;
                        step_in    = 2'd1;
                        bit_idx_in = 4'd0;
                     end else begin
                        unique case (phase_in)
                           PH_ADDRW: begin
                              phase_in = PH_REG;
                              shift_in = reg_in;
                           end
                           PH_REG: begin
                              if (is_read_in) begin
                                 phase_in = PH_START2;
                              end else begin
                                 phase_in = (left_in != '0) ? PH_DATA : PH_STOP;
                              end
                           end
                           PH_DATA: begin
                              left_in  = left_in - COUNT_WIDTH'(1);
                              phase_in = (left_in != '0) ? PH_DATA : PH_STOP;
                           end
                           default: begin
                              phase_in = (left_in != '0) ? PH_RECV : PH_STOP;
                              shift_in = 8'd0;
                           end
                        endcase
                        step_in    = 2'd0;
                        bit_idx_in = 4'd0;
                        chain      = 1'b1;
                     end
                  end
               endcase
            end
         end
         PH_RECV: begin
            if (step_in == 2'd0) begin
               scl_in  = 1'b0;
               sda_in  = 1'b1;
               step_in = 2'd1;
            end else begin
               scl_in     = 1'b1;
               shift_in   = {shift_in[6:0], cmd.sda_sample};
               bit_idx_in = bit_idx_in + 4'd1;
               step_in    = 2'd0;
               if (bit_idx_in[3]) begin
                  res_in.read_byte  = shift_in;
                  res_in.read_valid = 1'b1;
                  res_in.read_last  = (left_in == COUNT_WIDTH'(1));
                  phase_in          = PH_MACK;
                  bit_idx_in        = 4'd0;
               end
            end
         end
         PH_MACK: begin
            case (step_in)
               2'd0: begin
                  scl_in  = 1'b0;
                  sda_in  = (left_in == COUNT_WIDTH'(1));
                  step_in = 2'd1;
               end
               2'd1: begin scl_in = 1'b1; step_in = 2'd2; end
               default: begin
                  scl_in   = 1'b0;
                  left_in  = left_in - COUNT_WIDTH'(1);
                  phase_in = (left_in != '0) ? PH_RECV : PH_STOP;
                  shift_in = 8'd0;
                  step_in  = 2'd0;
               end
            endcase
         end
         PH_STOP: begin
            case (step_in)
               2'd0: begin sda_in = 1'b0; step_in = 2'd1; end
               2'd1: begin scl_in = 1'b1; step_in = 2'd2; end
               default: begin
                  sda_in      = 1'b1;
                  phase_in    = PH_IDLE;
                  step_in     = 2'd0;
                  res_in.done = 1'b1;
               end
            endcase
         end
         default: begin
            phase_in = PH_IDLE;
            step_in  = 2'd0;
         end
      endcase

      // after an ACK the first step of the next phase runs in the same tick
      if (chain) begin
         unique case (phase_in)
            PH_START2: begin sda_in = 1'b1; step_in = 2'd1; end
            PH_RECV: begin
               scl_in  = 1'b0;
               sda_in  = 1'b1;
               step_in = 2'd1;
            end
            PH_STOP: begin sda_in = 1'b0; step_in = 2'd1; end
            PH_DATA: begin
               if (!held_valid_in) begin
                  res_in.need_byte = 1'b1;
               end else begin
                  shift_in      = held_in;
                  held_valid_in = 1'b0;
                  sda_in        = shift_in[7];
                  step_in       = 2'd1;
               end
            end
            default: begin
               sda_in  = shift_in[7];
               step_in = 2'd1;
            end
         endcase
      end

      res_in.scl_level  = scl_in;
      res_in.sda_level  = sda_in;
      res_in.busy       = (phase_in != PH_IDLE);
      res_in.error_code = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         step_ff       <= 2'd0;
         bit_idx_ff    <= 4'd0;
         held_valid_ff <= 1'b0;
         is_read_ff    <= 1'b0;
         err_ff        <= ERR_OK;
         scl_ff        <= 1'b1;
         sda_ff        <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (advance) begin
            phase_ff      <= phase_in;
            step_ff       <= step_in;
            bit_idx_ff    <= bit_idx_in;
            held_valid_ff <= held_valid_in;
            is_read_ff    <= is_read_in;
            err_ff        <= err_in;
            scl_ff        <= scl_in;
            sda_ff        <= sda_in;
            rsp_valid_ff  <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         shift_ff <= shift_in;
         left_ff  <= left_in;
         held_ff  <= held_in;
         slave_ff <= slave_in;
         reg_ff   <= reg_in;
         rsp_ff   <= res_in;
      end
   end

   `ASSERT_NEXT(a_recv_to_mack, clock, reset, advance && res_in.read_valid, phase_ff == PH_MACK)
   `ASSERT_IMPLIES(a_need_in_data, clock, reset, res_in.need_byte, phase_in == PH_DATA && bit_idx_in == 4'd0)
   `ASSERT_IMPLIES(a_bit_range, clock, reset, 1'b1, bit_idx_ff <= 4'd8)
   `ASSERT_NEXT(a_done_idle, clock, reset, advance && res_in.done, phase_ff == PH_IDLE && !scl_ff == 1'b0)

endmodule

FILE: src/i2c_master_register_access.sv
// Top level of the seven-bit I2C master for register read and write access.
//
// Request channel (req_): one transfer per quarter-bit bus tick. tuser carries
// the opcode (tick, start write, start read, supply write byte); tdata carries
// the address, register, byte count, write byte and the sampled SDA level.
// Result channel (rsp_): exactly one transfer per request, in order, holding
// the SCL/SDA drive levels after the tick, the received byte (tuser flags it,
// tlast marks the final byte), need-byte, busy, done and the error code.
// Requests enter a two-deep queue; the sequencer takes one per cycle while the
// result side accepts and loads the result register, so a result appears in the
// cycle after its request is taken and one tick per cycle is sustained. The rate
// is set by the tick step of the sequencer.
// When the result side stalls the result register holds, the queue fills and
// req_tready drops once two requests wait.
// Reset empties the queue and leaves the bus idle with SCL and SDA released.
module i2c_master_register_access
   import i2cm_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // dev_addr[6:0], reg_addr[14:7], byte_count[30:15], write_byte[38:31], sda_in[39]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // opcode[1:0]
   input  logic [1:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // scl_level[0], sda_level[1], read_byte[9:2], need_byte[10], busy_res[11],
   // done_res[12], error_code[15:13]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // read_valid[0]
   output logic                  rsp_tuser,
   output logic                  rsp_tlast
);

   cmd_type    cmd;
   logic       cmd_valid;
   logic       cmd_pop;
   result_type rsp;

   i2cm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .cmd_valid  (cmd_valid),
      .cmd        (cmd),
      .cmd_pop    (cmd_pop)
   );

   i2cm_engine #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tdata = {rsp.error_code, rsp.done, rsp.busy, rsp.need_byte,
                       rsp.read_byte, rsp.sda_level, rsp.scl_level};
   assign rsp_tuser = rsp.read_valid;
   assign rsp_tlast = rsp.read_last;

endmodule
